/* rtl/core/array_linked_list_manager_assert.svh */
// assertion helpers for the linked list manager
`ifndef ARRAY_LINKED_LIST_MANAGER_ASSERT_SVH
`define ARRAY_LINKED_LIST_MANAGER_ASSERT_SVH

// implication checked at every clock edge outside reset
`define ALLM_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define ALLM_ASSERT_NXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

/* rtl/core/allm_pkg.sv */
package allm_pkg;

	// default geometry
	localparam int SLOTS_DEF      = 255;
	localparam int VALUE_BITS_DEF = 64;

	// operation codes
	localparam logic [2:0] OP_INS_AFTER  = 3'd0;
	localparam logic [2:0] OP_INS_BEFORE = 3'd1;
	localparam logic [2:0] OP_REMOVE     = 3'd2;
	localparam logic [2:0] OP_READ       = 3'd3;
	localparam logic [2:0] OP_NEXT       = 3'd4;
	localparam logic [2:0] OP_PREV       = 3'd5;
	localparam logic [2:0] OP_LOCATE     = 3'd6;
	localparam logic [2:0] OP_CLEAR      = 3'd7;

	// status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_RANGE  = 3'd1;
	localparam logic [2:0] ST_NULL   = 3'd2;
	localparam logic [2:0] ST_UNUSED = 3'd3;
	localparam logic [2:0] ST_FULL   = 3'd4;

endpackage

/* rtl/core/allm_ram.sv */
module allm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read returning old data on a collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/array_linked_list_manager.sv */
// Doubly linked list of values in SLOTS+1 node slots (slot 0 is the head/tail
// sentinel) with a free chain, one operation per transaction and one result
// each. Links and in-use bits share one memory word per slot, values sit in a
// second memory; every access goes through their single write port and
// registered read port, so timing is set by the number of entries touched;
// locate with the in-order flag reads one entry, locate by walking follows
// the links up to the ordinal, and clear rewrites every slot. After reset a
// clearing pass over every slot rebuilds the link memory before the first
// transaction is taken. A finished result waits in the output register while
// the next transaction is already accepted.
`include "array_linked_list_manager_assert.svh"

module array_linked_list_manager #(
	parameter int SLOTS      = allm_pkg::SLOTS_DEF,
	parameter int VALUE_BITS = allm_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [7:0]  slot,
	input  logic [7:0]  ordinal,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  result_slot,
	output logic [63:0] read_value,
	output logic [2:0]  status
);
	import allm_pkg::*;

	localparam int IW = $clog2(SLOTS + 1);
	localparam int LW = 2 * IW + 1;
	localparam logic [16:0] SLOTS_W = 17'(SLOTS);

	localparam logic [3:0] S_SWEEP = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_RN    = 4'd3;
	localparam logic [3:0] S_RA    = 4'd4;
	localparam logic [3:0] S_RB    = 4'd5;
	localparam logic [3:0] S_WS    = 4'd6;
	localparam logic [3:0] S_WALK  = 4'd7;
	localparam logic [3:0] S_LOCF  = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0]            state_q, state_d;
	logic [2:0]            op_q;
	logic [IW-1:0]         slot_q, a_q, b_q, n_q, fh_q, sw_q, res_q;
	logic [IW-1:0]         a_d, b_d, n_d, fh_d, sw_d, res_d;
	logic [7:0]            ord_q, cnt_q, cnt_d;
	logic [VALUE_BITS-1:0] val_q;
	logic                  flag_q, flag_d, swres_q, swres_d;
	logic [63:0]           rv_q, rv_d;
	logic [2:0]            st_q, st_d;
	logic                  accept, take;

	logic                  l_we;
	logic [IW-1:0]         l_waddr, l_raddr;
	logic [LW-1:0]         l_wdata, l_ram, rd;
	logic                  v_we;
	logic [VALUE_BITS-1:0] v_rd;
	logic                  byp_q;
	logic [LW-1:0]         byp_data_q;

	logic [16:0]           slot_w, loc_c;
	logic [IW-1:0]         rd_next, rd_prev;
	logic                  rd_used;

	allm_ram #(.WIDTH(LW), .DEPTH(SLOTS + 1)) u_link (
		.clk  (clk),
		.we   (l_we),
		.waddr(l_waddr),
		.wdata(l_wdata),
		.raddr(l_raddr),
		.rdata(l_ram)
	);

	allm_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS + 1)) u_value (
		.clk  (clk),
		.we   (v_we),
		.waddr(n_q),
		.wdata(val_q),
		.raddr(IW'(slot)),
		.rdata(v_rd)
	);

	// forward a write that collided with the read of the same entry
	assign rd      = byp_q ? byp_data_q : l_ram;
	assign rd_next = rd[IW-1:0];
	assign rd_prev = rd[2*IW-1:IW];
	assign rd_used = rd[2*IW];

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign take     = !out_valid || !out_stall;
	assign slot_w   = {9'd0, slot};
	assign loc_c    = {9'd0, ordinal} + 17'd1;

	// operation sequencer
	always_comb begin
		state_d = state_q;
		a_d     = a_q;
		b_d     = b_q;
		n_d     = n_q;
		fh_d    = fh_q;
		sw_d    = sw_q;
		res_d   = res_q;
		cnt_d   = cnt_q;
		flag_d  = flag_q;
		swres_d = swres_q;
		rv_d    = rv_q;
		st_d    = st_q;
		l_we    = 1'b0;
		l_waddr = '0;
		l_wdata = '0;
		l_raddr = '0;
		v_we    = 1'b0;
		unique case (state_q)
			S_SWEEP: begin
				l_we    = 1'b1;
				l_waddr = sw_q;
				l_wdata = {(sw_q == '0), {IW{1'b0}},
					((sw_q == '0) || (17'(sw_q) == SLOTS_W)) ? {IW{1'b0}} : sw_q + 1'b1};
				sw_d    = sw_q + 1'b1;
				if (17'(sw_q) == SLOTS_W) begin
					fh_d    = IW'(1);
					flag_d  = 1'b1;
					state_d = swres_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				res_d = '0;
				rv_d  = '0;
				st_d  = ST_OK;
				if (accept) begin
					priority if (opcode == OP_LOCATE) begin
						if ({9'd0, ordinal} > SLOTS_W) begin
							st_d    = ST_RANGE;
							state_d = S_DONE;
						end else if (flag_q) begin
							if (loc_c > SLOTS_W) begin
								state_d = S_DONE;
							end else begin
								a_d     = IW'(loc_c);
								l_raddr = IW'(loc_c);
								state_d = S_LOCF;
							end
						end else begin
							cnt_d   = '0;
							state_d = S_WALK;
						end
					end else if (opcode == OP_CLEAR) begin
						sw_d    = '0;
						swres_d = 1'b1;
						state_d = S_SWEEP;
					end else if ((opcode == OP_REMOVE || opcode == OP_READ) && slot == 8'd0) begin
						st_d    = ST_NULL;
						state_d = S_DONE;
					end else if (slot_w > SLOTS_W) begin
						st_d    = ST_RANGE;
						state_d = S_DONE;
					end else begin
						l_raddr = IW'(slot);
						state_d = S_CHK;
					end
				end
			end
			S_CHK: begin
				if (!rd_used) begin
					st_d    = ST_UNUSED;
					state_d = S_DONE;
				end else begin
					unique case (op_q)
						OP_READ: begin
							rv_d    = 64'(v_rd);
							state_d = S_DONE;
						end
						OP_NEXT: begin
							res_d   = rd_next;
							state_d = S_DONE;
						end
						OP_PREV: begin
							res_d   = rd_prev;
							state_d = S_DONE;
						end
						OP_REMOVE: begin
							a_d     = rd_prev;
							b_d     = rd_next;
							l_raddr = rd_prev;
							state_d = S_RA;
						end
						default: begin
							if (fh_q == '0) begin
								st_d    = ST_FULL;
								state_d = S_DONE;
							end else begin
								a_d     = (op_q == OP_INS_AFTER) ? slot_q : rd_prev;
								b_d     = (op_q == OP_INS_AFTER) ? rd_next : slot_q;
								n_d     = fh_q;
								l_raddr = fh_q;
								state_d = S_RN;
							end
						end
					endcase
				end
			end
			S_RN: begin
				// take the new node off the free chain
				fh_d    = rd_next;
				l_we    = 1'b1;
				l_waddr = n_q;
				l_wdata = {1'b1, a_q, b_q};
				v_we    = 1'b1;
				l_raddr = a_q;
				state_d = S_RA;
			end
			S_RA: begin
				l_we    = 1'b1;
				l_waddr = a_q;
				l_wdata = {rd_used, rd_prev, (op_q == OP_REMOVE) ? b_q : n_q};
				l_raddr = b_q;
				state_d = S_RB;
			end
			S_RB: begin
				l_we    = 1'b1;
				l_waddr = b_q;
				l_wdata = {rd_used, (op_q == OP_REMOVE) ? a_q : n_q, rd_next};
				if (b_q != '0) begin
					flag_d = 1'b0;
				end
				if (op_q == OP_REMOVE) begin
					state_d = S_WS;
				end else begin
					res_d   = n_q;
					state_d = S_DONE;
				end
			end
			S_WS: begin
				// return the removed node to the free chain
				l_we    = 1'b1;
				l_waddr = slot_q;
				l_wdata = {1'b0, {IW{1'b0}}, fh_q};
				fh_d    = slot_q;
				state_d = S_DONE;
			end
			S_WALK: begin
				if (cnt_q == ord_q || rd_next == '0) begin
					res_d   = rd_next;
					state_d = S_DONE;
				end else begin
					cnt_d   = cnt_q + 8'd1;
					l_raddr = rd_next;
				end
			end
			S_LOCF: begin
				res_d   = rd_used ? a_q : '0;
				state_d = S_DONE;
			end
			S_DONE: begin
				swres_d = 1'b0;
				if (take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SWEEP;
			sw_q      <= '0;
			swres_q   <= 1'b0;
			fh_q      <= IW'(1);
			flag_q    <= 1'b1;
			out_valid <= 1'b0;
			byp_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			sw_q    <= sw_d;
			swres_q <= swres_d;
			fh_q    <= fh_d;
			flag_q  <= flag_d;
			byp_q   <= l_we && (l_waddr == l_raddr);
			if (state_q == S_DONE && take) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		byp_data_q <= l_wdata;
		a_q        <= a_d;
		b_q        <= b_d;
		n_q        <= n_d;
		res_q      <= res_d;
		cnt_q      <= cnt_d;
		rv_q       <= rv_d;
		st_q       <= st_d;
		if (accept) begin
			op_q   <= opcode;
			slot_q <= IW'(slot);
			ord_q  <= ordinal;
			val_q  <= VALUE_BITS'(value);
		end
		if (state_q == S_DONE && take) begin
			result_slot <= 8'(res_q);
			read_value  <= rv_q;
			status      <= st_q;
		end
	end

	`ALLM_ASSERT_IMP(a_err_clean, out_valid && status != ST_OK,
		result_slot == 8'd0 && read_value == 64'd0, "error result carries data")
	`ALLM_ASSERT_IMP(a_idle_no_write, state_q == S_IDLE, !l_we, "memory written while idle")
	`ALLM_ASSERT_IMP(a_walk_bound, state_q == S_WALK, cnt_q <= ord_q, "walk ran past ordinal")
	`ALLM_ASSERT_NXT(a_done_out, state_q == S_DONE && take, out_valid,
		"finished result not presented")

endmodule
